// ===== design/addressed_serial_frame_receiver_defines.svh =====
// Assertion helpers for the frame receiver. Clock is clk_i, reset is rst_ni.
`ifndef ADDRESSED_SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define ADDRESSED_SERIAL_FRAME_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
`define ASFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("asfr assertion failed");
`define ASFR_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define ASFR_ASSERT(lbl, prop)
`define ASFR_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

// ===== design/asfr_pkg.sv =====
package asfr_pkg;

  localparam int PAYLOAD_DEPTH = 256;
  localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

  localparam logic [7:0] LONG_ADDR_BYTES = 8'd12;

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_AW    = $clog2(OUT_FIFO_DEPTH);
  localparam int OUT_FIFO_CW    = $clog2(OUT_FIFO_DEPTH + 1);

  // line constants
  localparam logic [7:0] START_BYTE = 8'hBE;
  localparam logic [7:0] FLAGS_MASK = 8'hF0;
  localparam logic [7:0] FLAGS_TAG  = 8'h50;
  localparam int         FLAG_SKIP_BIT = 0;
  localparam int         FLAG_LONG_BIT = 2;

  // parse phases
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_FLAGS   = 3'd1;
  localparam logic [2:0] PH_ADDR    = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SUM_LO  = 3'd5;
  localparam logic [2:0] PH_SUM_HI  = 3'd6;

  // request / result kinds
  localparam logic REQ_LINE_BYTE = 1'b0;
  localparam logic REQ_READ      = 1'b1;
  localparam logic KIND_REPORT   = 1'b0;
  localparam logic KIND_READ     = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_DELIVERED = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_BAD_SUM   = 2'd2;

  // register indexes
  localparam logic [7:0] REG_STATION_ID = 8'd0;
  localparam logic [7:0] REG_UUID_WORD0 = 8'd1;
  localparam logic [7:0] REG_UUID_WORD1 = 8'd2;
  localparam logic [7:0] REG_UUID_WORD2 = 8'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] frame_status;
    logic [7:0] frame_length;
    logic [7:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  station_id;
    logic [31:0] uuid_word0;
    logic [31:0] uuid_word1;
    logic [31:0] uuid_word2;
  } cfg_t;

  typedef struct packed {
    logic                  en;
    logic [PAYLOAD_AW-1:0] addr;
    logic [7:0]            data;
  } pay_wr_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [7:0] length;
  } report_t;

endpackage

// ===== design/addressed_serial_frame_receiver.sv =====
// A result passes through the parse/RAM read stage and then the result queue
//   head before it appears on out_valid_o.
// Throughput: one item per cycle; input stalls only when the 4-entry result
//   queue plus the in-flight stage hold four results.
// Reset (rst_ni, async low): parser waits for a start byte, registers clear,
//   result queue empties. Payload RAM is not cleared.
`include "addressed_serial_frame_receiver_defines.svh"

module addressed_serial_frame_receiver
  import asfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Register file. The user must write these only while the receiver is idle;
  // the block itself does not enforce this. The parser reads them with no shadowing.
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_STATION_ID: cfg_q.station_id <= cfg_data_i[7:0];
        REG_UUID_WORD0: cfg_q.uuid_word0 <= cfg_data_i;
        REG_UUID_WORD1: cfg_q.uuid_word1 <= cfg_data_i;
        REG_UUID_WORD2: cfg_q.uuid_word2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input transfer. Line bytes go to the parser, reads go to the payload RAM.
  // Both can never happen in the same cycle since one item arrives per cycle,
  // and a RAM write is visible to any read issued after it.
  // ---------------------------------------------------------------------------
  logic in_xfer, line_xfer, read_xfer;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign line_xfer = in_xfer && (in_item_i.req_type == REQ_LINE_BYTE);
  assign read_xfer = in_xfer && (in_item_i.req_type == REQ_READ);

  pay_wr_t    pay_wr;
  report_t    report;
  logic [7:0] rd_data;

  asfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (line_xfer),
    .rx_byte_i    (in_item_i.rx_byte),
    .cfg_i        (cfg_q),
    .pay_wr_o     (pay_wr),
    .report_o     (report)
  );

  asfr_payload_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (pay_wr),
    .rd_en_i   (read_xfer),
    .rd_addr_i (in_item_i.read_index[PAYLOAD_AW-1:0]),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Result stage: lines up the end-of-frame report with the registered RAM
  // read data. It never stalls; it always drains into the queue next cycle.
  // ---------------------------------------------------------------------------
  logic       p1_valid_q;
  logic       p1_kind_q;
  logic [1:0] p1_status_q;
  logic [7:0] p1_length_q;
  out_item_t  p1_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= report.valid || read_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_xfer) begin
      p1_kind_q   <= KIND_READ;
      p1_status_q <= ST_DELIVERED;
      p1_length_q <= 8'd0;
    end else if (report.valid) begin
      p1_kind_q   <= KIND_REPORT;
      p1_status_q <= report.status;
      p1_length_q <= report.length;
    end
  end

  always_comb begin
    p1_item.result_kind  = p1_kind_q;
    p1_item.frame_status = p1_status_q;
    p1_item.frame_length = p1_length_q;
    p1_item.read_data    = (p1_kind_q == KIND_READ) ? rd_data : 8'd0;
  end

  // ---------------------------------------------------------------------------
  // Result queue. Stall comes from registered occupancy only, counting the
  // result already in flight, so the queue can never overflow.
  // ---------------------------------------------------------------------------
  logic [OUT_FIFO_CW-1:0] q_count;
  logic [OUT_FIFO_CW:0]   occupancy;

  asfr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (p1_valid_q),
    .push_item_i (p1_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .count_o     (q_count)
  );

  assign occupancy  = {1'b0, q_count} + {{OUT_FIFO_CW{1'b0}}, p1_valid_q};
  assign in_stall_o = occupancy >= (OUT_FIFO_CW + 1)'(OUT_FIFO_DEPTH);

  `ASFR_ASSERT_MSG(a_read_replies, read_xfer |=> p1_valid_q && p1_kind_q == KIND_READ, "read reply missing")

endmodule

// ===== design/asfr_payload_ram.sv =====
module asfr_payload_ram
  import asfr_pkg::*;
(
  input  logic                  clk_i,
  input  pay_wr_t               wr_i,
  input  logic                  rd_en_i,
  input  logic [PAYLOAD_AW-1:0] rd_addr_i,
  output logic [7:0]            rd_data_o
);

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/asfr_parser.sv =====
`include "addressed_serial_frame_receiver_defines.svh"

module asfr_parser
  import asfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output pay_wr_t    pay_wr_o,
  output report_t    report_o
);

  logic [2:0]  phase_q, phase_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  sum_lo_q, sum_lo_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic        skip_q, skip_d;
  logic        long_q, long_d;

  logic [15:0] sum_shift;
  logic [31:0] uuid_word;
  logic [7:0]  uuid_byte;

  assign sum_shift = {sum_q[14:0], 1'b0} ^ {8'h00, rx_byte_i};

  always_comb begin
    case (pos_q[3:2])
      2'd0:    uuid_word = cfg_i.uuid_word0;
      2'd1:    uuid_word = cfg_i.uuid_word1;
      default: uuid_word = cfg_i.uuid_word2;
    endcase
  end

  assign uuid_byte = uuid_word[{pos_q[1:0], 3'b000} +: 8];

  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    sum_lo_d = sum_lo_q;
    len_d    = len_q;
    pos_d    = pos_q;
    skip_d   = skip_q;
    long_d   = long_q;
    pay_wr_o = '0;
    report_o = '0;
    if (byte_valid_i) begin
      case (phase_q)
        PH_START: begin
          if (rx_byte_i == START_BYTE) begin
            sum_d   = {8'h00, rx_byte_i};
            phase_d = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          sum_d = sum_shift;
          if ((rx_byte_i & FLAGS_MASK) != FLAGS_TAG) begin
            phase_d = PH_START;
          end else begin
            skip_d  = rx_byte_i[FLAG_SKIP_BIT];
            long_d  = rx_byte_i[FLAG_LONG_BIT];
            pos_d   = 8'd0;
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          sum_d = sum_shift;
          if (long_q) begin
            if (rx_byte_i != uuid_byte) begin
              skip_d = 1'b1;
            end
            pos_d = pos_q + 8'd1;
            if (pos_q + 8'd1 >= LONG_ADDR_BYTES) begin
              phase_d = PH_LENGTH;
            end
          end else begin
            if (rx_byte_i != cfg_i.station_id) begin
              skip_d = 1'b1;
            end
            phase_d = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          sum_d = sum_shift;
          if (rx_byte_i == 8'd0) begin
            phase_d = PH_START;
          end else begin
            len_d   = rx_byte_i;
            pos_d   = 8'd0;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_d         = sum_shift;
          pay_wr_o.en   = 1'b1;
          pay_wr_o.addr = pos_q[PAYLOAD_AW-1:0];
          pay_wr_o.data = rx_byte_i;
          if ({1'b0, pos_q} + 9'd1 >= {1'b0, len_q}) begin
            phase_d = PH_SUM_LO;
          end
          if (pos_q != 8'hFF) begin
            pos_d = pos_q + 8'd1;
          end
        end
        PH_SUM_LO: begin
          sum_lo_d = rx_byte_i;
          phase_d  = PH_SUM_HI;
        end
        PH_SUM_HI: begin
          phase_d         = PH_START;
          report_o.valid  = 1'b1;
          report_o.length = len_q;
          if ({rx_byte_i, sum_lo_q} != sum_q) begin
            report_o.status = ST_BAD_SUM;
          end else if (skip_q) begin
            report_o.status = ST_IGNORED;
          end else begin
            report_o.status = ST_DELIVERED;
          end
        end
        default: begin
          phase_d = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      sum_q    <= '0;
      sum_lo_q <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      skip_q   <= 1'b0;
      long_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      sum_lo_q <= sum_lo_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      skip_q   <= skip_d;
      long_q   <= long_d;
    end
  end

  `ASFR_ASSERT_MSG(a_report_restarts, report_o.valid |=> phase_q == PH_START, "no restart after report")
  `ASFR_ASSERT_MSG(a_payload_len_nz, phase_q == PH_PAYLOAD |-> len_q != 8'd0, "payload with zero length")
  `ASFR_ASSERT_MSG(a_addr_pos_bound, phase_q == PH_ADDR |-> pos_q < LONG_ADDR_BYTES, "long address overrun")

endmodule

// ===== design/asfr_out_fifo.sv =====
`include "addressed_serial_frame_receiver_defines.svh"

module asfr_out_fifo
  import asfr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  out_item_t              push_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o,
  output logic [OUT_FIFO_CW-1:0] count_o
);

  out_item_t              entries_q [OUT_FIFO_DEPTH];
  logic [OUT_FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_FIFO_CW-1:0] count_q, count_d;
  logic                   pop;

  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_item_o  = entries_q[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + OUT_FIFO_CW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - OUT_FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_FIFO_AW'(1);
      end
      count_q <= count_d;
    end
  end

  `ASFR_ASSERT_MSG(a_no_overflow, push_i && !pop |-> count_q < OUT_FIFO_CW'(OUT_FIFO_DEPTH), "result queue overflow")

endmodule
